// ===== sv/bpa_pkg.sv =====
// shared types, constants and register codes of the block peak gain control
`default_nettype none
package bpa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int STEP_W   = 6;
  localparam int VOL_W    = 7;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 15;
  localparam int SUM_W    = 9;

  localparam int MIN_VOLUME_DEF     = 10;
  localparam int INITIAL_VOLUME_DEF = 90;

  localparam logic [MAG_W-1:0]  THR_HIGH_RST = 15'd28000;
  localparam logic [MAG_W-1:0]  THR_LOW_RST  = 15'd24000;
  localparam logic [MAG_W-1:0]  THR_MOD_RST  = 15'd20000;
  localparam logic [STEP_W-1:0] STEP_UF_RST  = 6'sd3;
  localparam logic [STEP_W-1:0] STEP_US_RST  = 6'sd1;
  localparam logic [STEP_W-1:0] STEP_DF_RST  = -6'sd8;
  localparam logic [STEP_W-1:0] STEP_DS_RST  = -6'sd2;
  localparam logic [VOL_W-1:0]  MAX_VOL_RST  = 7'd99;

  typedef enum logic [1:0] {
    CLASS_QUIET    = 2'd0,
    CLASS_MODERATE = 2'd1,
    CLASS_OVERFLOW = 2'd2,
    CLASS_NEAR     = 2'd3
  } level_class_t;

  typedef enum logic [IDX_W-1:0] {
    REG_THR_HIGH  = 3'd0,
    REG_THR_LOW   = 3'd1,
    REG_THR_MOD   = 3'd2,
    REG_STEP_UF   = 3'd3,
    REG_STEP_US   = 3'd4,
    REG_STEP_DF   = 3'd5,
    REG_STEP_DS   = 3'd6,
    REG_MAX_VOL   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [MAG_W-1:0]         thr_high;
    logic [MAG_W-1:0]         thr_low;
    logic [MAG_W-1:0]         thr_mod;
    logic signed [STEP_W-1:0] step_up_fast;
    logic signed [STEP_W-1:0] step_up_slow;
    logic signed [STEP_W-1:0] step_down_fast;
    logic signed [STEP_W-1:0] step_down_slow;
    logic [VOL_W-1:0]         max_volume;
  } cfg_t;

  typedef struct packed {
    level_class_t cls;
    logic         latched;
  } class_state_t;

endpackage
`default_nettype wire

// ===== sv/bpa_cfg_regs.sv =====
// configuration register file
`default_nettype none
module bpa_cfg_regs
  import bpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_THR_HIGH: cfg_next.thr_high       = wr_data[MAG_W-1:0];
        REG_THR_LOW:  cfg_next.thr_low        = wr_data[MAG_W-1:0];
        REG_THR_MOD:  cfg_next.thr_mod        = wr_data[MAG_W-1:0];
        REG_STEP_UF:  cfg_next.step_up_fast   = wr_data[STEP_W-1:0];
        REG_STEP_US:  cfg_next.step_up_slow   = wr_data[STEP_W-1:0];
        REG_STEP_DF:  cfg_next.step_down_fast = wr_data[STEP_W-1:0];
        REG_STEP_DS:  cfg_next.step_down_slow = wr_data[STEP_W-1:0];
        REG_MAX_VOL:  cfg_next.max_volume     = wr_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_high       <= THR_HIGH_RST;
      cfg.thr_low        <= THR_LOW_RST;
      cfg.thr_mod        <= THR_MOD_RST;
      cfg.step_up_fast   <= STEP_UF_RST;
      cfg.step_up_slow   <= STEP_US_RST;
      cfg.step_down_fast <= STEP_DF_RST;
      cfg.step_down_slow <= STEP_DS_RST;
      cfg.max_volume     <= MAX_VOL_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bpa_classify.sv =====
// per-sample magnitude and level class update
`default_nettype none
module bpa_classify
  import bpa_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire cfg_t                cfg,
  input  wire class_state_t        cur,
  output class_state_t             upd
);

  logic [SAMPLE_W-1:0] neg;
  logic [MAG_W-1:0]    mag;

  always_comb begin
    neg = SAMPLE_W'(0) - sample;
    if (!sample[SAMPLE_W-1]) begin
      mag = sample[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      mag = {MAG_W{1'b1}};
    end else begin
      mag = neg[MAG_W-1:0];
    end

    upd = cur;
    if (!cur.latched) begin
      if (mag > cfg.thr_high) begin
        upd.cls     = CLASS_OVERFLOW;
        upd.latched = 1'b1;
      end else begin
        if (mag > cfg.thr_mod) upd.cls = CLASS_MODERATE;
        if (mag > cfg.thr_low) upd.cls = CLASS_NEAR;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/bpa_gain.sv =====
// volume step selection and clamp at block end
`default_nettype none
module bpa_gain
  import bpa_pkg::*;
#(
  parameter int MIN_VOLUME = MIN_VOLUME_DEF
) (
  input  wire logic [VOL_W-1:0] gain,
  input  wire level_class_t     cls,
  input  wire cfg_t             cfg,
  output logic [VOL_W-1:0]      gain_next
);

  localparam logic signed [SUM_W-1:0] MIN_S = SUM_W'(MIN_VOLUME);

  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  max_s;

  always_comb begin
    case (cls)
      CLASS_QUIET:    step = cfg.step_up_fast;
      CLASS_MODERATE: step = cfg.step_up_slow;
      CLASS_OVERFLOW: step = cfg.step_down_fast;
      default:        step = cfg.step_down_slow;
    endcase
    sum   = $signed({2'b00, gain}) + SUM_W'(step);
    max_s = $signed({2'b00, cfg.max_volume});
    if (sum > max_s) begin
      gain_next = cfg.max_volume;
    end else if (sum <= MIN_S) begin
      gain_next = MIN_S[VOL_W-1:0];
    end else begin
      gain_next = sum[VOL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/block_peak_agc_unit.sv =====
// top level of the block peak gain control
//
//  port group     | dir | payload
//  s_t*           | in  | tdata[15:0] sample, tlast block end
//  m_t*           | out | tdata[6:0] volume, tuser[1:0] class, tuser[2] changed
//  cfg_*          | in  | cfg_index register, cfg_data value
//
// one sample per unstalled cycle: input register, class/gain logic, result register
// results register as their block end leaves the input register; a held one delays it
// a stalled result holds a block end in the input register; the input still
// takes a transfer whenever the input register empties in the same cycle
// synchronous reset restores thresholds, steps, volume INITIAL_VOLUME, clears the class
`default_nettype none
module block_peak_agc_unit
  import bpa_pkg::*;
#(
  parameter int MIN_VOLUME     = MIN_VOLUME_DEF,
  parameter int INITIAL_VOLUME = INITIAL_VOLUME_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // sample
  input  wire logic             s_tlast,   // block end
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // volume, zero pad
  output logic [2:0]            m_tuser,   // level class, volume changed
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t                cfg;
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_last;
  logic                advance;
  class_state_t        cstate;
  class_state_t        cstate_upd;
  logic [VOL_W-1:0]    gain;
  logic [VOL_W-1:0]    gain_next;
  logic [VOL_W-1:0]    applied;
  logic [VOL_W-1:0]    out_volume;
  level_class_t        out_class;
  logic                out_changed;

  assign cfg_ready = 1'b1;

  bpa_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpa_classify u_classify (
    .sample (in_sample),
    .cfg    (cfg),
    .cur    (cstate),
    .upd    (cstate_upd)
  );

  bpa_gain #(
    .MIN_VOLUME (MIN_VOLUME)
  ) u_gain (
    .gain      (gain),
    .cls       (cstate_upd.cls),
    .cfg       (cfg),
    .gain_next (gain_next)
  );

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_sample <= s_tdata;
      in_last   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate.cls     <= CLASS_QUIET;
      cstate.latched <= 1'b0;
      gain           <= VOL_W'(INITIAL_VOLUME);
      applied        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      m_tvalid <= (m_tvalid && !m_tready) || (advance && in_last);
      if (advance) begin
        if (in_last) begin
          cstate.cls     <= CLASS_QUIET;
          cstate.latched <= 1'b0;
          gain           <= gain_next;
          applied        <= gain_next;
        end else begin
          cstate <= cstate_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_volume  <= gain_next;
      out_class   <= cstate_upd.cls;
      out_changed <= (gain_next != applied);
    end
  end

  assign m_tdata = {1'b0, out_volume};
  assign m_tuser = {out_changed, out_class};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input not ready while the input register is empty");

  a_result_follows_end: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("no result after a block-end sample");

  a_latch_means_overflow: assert property (@(posedge clk) disable iff (rst)
    cstate.latched |-> cstate.cls == CLASS_OVERFLOW)
    else $error("overflow latch set without overflow class");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tdata))
    else $error("held result overwritten");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for block_peak_agc_unit: directed and random sample blocks against a gain predictor
module tb;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAG_CAP        = 2**MAG_W - 1;
  localparam int NUM_REGS       = 8;
  localparam int PHASE_SAMPLES  = 110;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } agc_sample_t;

  typedef struct {
    logic [VOL_W-1:0] volume;
    level_class_t     cls;
    logic             changed;
  } volume_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata  = '0;  // sample
  logic                s_tlast  = 1'b0;  // block end
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;  // volume, zero pad
  logic [2:0]          m_tuser;  // level class, volume changed
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  block_peak_agc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  agc_sample_t    sample_backlog [$];
  volume_report_t volume_reports [$];
  int samples_queued = 0;
  int samples_taken  = 0;
  int errors         = 0;

  // predictor copy of settings and state
  logic [MAG_W-1:0] thr_high, thr_low, thr_mod;
  int               class_step [4];
  int               max_vol;
  int               gain, applied;
  level_class_t     run_class;
  logic             peak_latched;

  function automatic void reset_predictor();
    thr_high = THR_HIGH_RST;
    thr_low  = THR_LOW_RST;
    thr_mod  = THR_MOD_RST;
    class_step[CLASS_QUIET]    = $signed(STEP_UF_RST);
    class_step[CLASS_MODERATE] = $signed(STEP_US_RST);
    class_step[CLASS_OVERFLOW] = $signed(STEP_DF_RST);
    class_step[CLASS_NEAR]     = $signed(STEP_DS_RST);
    max_vol      = MAX_VOL_RST;
    gain         = INITIAL_VOLUME_DEF;
    applied      = 0;
    run_class    = CLASS_QUIET;
    peak_latched = 1'b0;
  endfunction

  function automatic void take_setting(reg_index_t idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_THR_HIGH: thr_high = v[MAG_W-1:0];
      REG_THR_LOW:  thr_low  = v[MAG_W-1:0];
      REG_THR_MOD:  thr_mod  = v[MAG_W-1:0];
      REG_STEP_UF:  class_step[CLASS_QUIET]    = $signed(v[STEP_W-1:0]);
      REG_STEP_US:  class_step[CLASS_MODERATE] = $signed(v[STEP_W-1:0]);
      REG_STEP_DF:  class_step[CLASS_OVERFLOW] = $signed(v[STEP_W-1:0]);
      REG_STEP_DS:  class_step[CLASS_NEAR]     = $signed(v[STEP_W-1:0]);
      REG_MAX_VOL:  max_vol = v[VOL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void agc_predict(logic [SAMPLE_W-1:0] raw, logic last);
    logic [SAMPLE_W-1:0] mag;
    volume_report_t      rep;
    mag = raw[SAMPLE_W-1] ? (16'h0 - raw) : raw;
    // most negative sample saturates
    if (mag > MAG_CAP) mag = SAMPLE_W'(MAG_CAP);
    if (!peak_latched) begin
      if (mag > thr_high) begin
        run_class    = CLASS_OVERFLOW;
        peak_latched = 1'b1;
      end else begin
        if (mag > thr_mod) run_class = CLASS_MODERATE;
        if (mag > thr_low) run_class = CLASS_NEAR;
      end
    end
    if (last) begin
      gain = gain + class_step[run_class];
      if (gain > max_vol) gain = max_vol;
      else if (gain <= MIN_VOLUME_DEF) gain = MIN_VOLUME_DEF;
      rep.volume  = VOL_W'(gain);
      rep.cls     = run_class;
      rep.changed = (gain != applied);
      applied     = gain;
      volume_reports.push_back(rep);
      run_class    = CLASS_QUIET;
      peak_latched = 1'b0;
    end
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    agc_sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        agc_predict(s_tdata, s_tlast);
        samples_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          nxt = sample_backlog.pop_front();
          s_tdata  <= nxt.sample;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern in stretches, one long hold-off
  int   ready_mode = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && samples_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (ready_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    volume_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (volume_reports.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got volume %0d class %0d changed %0d",
                 $time, m_tdata[VOL_W-1:0], m_tuser[1:0], m_tuser[2]);
        errors++;
      end else begin
        want = volume_reports.pop_front();
        if (m_tdata[VOL_W-1:0] !== want.volume) begin
          $display("%0t ns: volume expected %0d got %0d", $time, want.volume, m_tdata[VOL_W-1:0]);
          errors++;
        end
        if (m_tdata[7] !== 1'b0) begin
          $display("%0t ns: tdata pad expected 0 got %b", $time, m_tdata[7]);
          errors++;
        end
        if (m_tuser[1:0] !== want.cls) begin
          $display("%0t ns: level class expected %0d got %0d", $time, want.cls, m_tuser[1:0]);
          errors++;
        end
        if (m_tuser[2] !== want.changed) begin
          $display("%0t ns: volume changed expected %0d got %0d", $time, want.changed, m_tuser[2]);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void add_sample(logic [SAMPLE_W-1:0] s, logic last);
    agc_sample_t it;
    it.sample = s;
    it.last   = last;
    sample_backlog.push_back(it);
    samples_queued++;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int cap, logic [MAG_W-1:0] edges [3]);
    int roll;
    int mag;
    roll = $urandom_range(0, 29);
    if (roll == 0) return 16'h8000;
    if (roll == 1) mag = MAG_CAP;
    else if (roll == 2) mag = 0;
    else if (roll < 8) begin
      // just around one of the thresholds
      mag = int'(edges[$urandom_range(0, 2)]) + $urandom_range(0, 4) - 2;
      if (mag < 0) mag = 0;
      if (mag > MAG_CAP) mag = MAG_CAP;
    end else begin
      mag = $urandom_range(0, cap);
    end
    return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  task automatic settle();
    while (samples_taken != samples_queued || volume_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= reg_index_t'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      take_setting(reg_index_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] step_code(int s);
    return CFG_W'(STEP_W'(s));
  endfunction

  initial begin
    logic [CFG_W-1:0] vals [NUM_REGS];
    logic [MAG_W-1:0] edges [3];
    int               trio [$];
    int               cap, len, count;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed blocks at reset settings
    add_sample(16'd0, 1'b1);
    add_sample(16'd100, 1'b0);
    add_sample(-16'sd20000, 1'b0);
    add_sample(16'd20000, 1'b1);
    add_sample(16'd20001, 1'b1);
    add_sample(-16'sd24001, 1'b0);
    add_sample(16'd5, 1'b1);
    // near then moderate falls back to moderate
    add_sample(16'd24001, 1'b0);
    add_sample(-16'sd20001, 1'b1);
    // overflow latches, later samples ignored
    add_sample(16'd28001, 1'b0);
    add_sample(16'd0, 1'b0);
    add_sample(-16'sd24001, 1'b1);
    add_sample(16'h8000, 1'b1);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'd1, 1'b1);
    add_sample(16'hffff, 1'b0);
    add_sample(-16'sd32767, 1'b1);
    add_sample(16'd24000, 1'b0);
    add_sample(16'd28000, 1'b1);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          vals[REG_THR_HIGH] = '0;
          vals[REG_THR_LOW]  = '0;
          vals[REG_THR_MOD]  = '0;
          vals[REG_STEP_UF]  = step_code(-16);
          vals[REG_STEP_US]  = step_code(-16);
          vals[REG_STEP_DF]  = step_code(-16);
          vals[REG_STEP_DS]  = step_code(-16);
          vals[REG_MAX_VOL]  = '0;
        end
        1: begin
          vals[REG_THR_HIGH] = CFG_W'(MAG_CAP);
          vals[REG_THR_LOW]  = CFG_W'(MAG_CAP);
          vals[REG_THR_MOD]  = CFG_W'(MAG_CAP);
          vals[REG_STEP_UF]  = step_code(16);
          vals[REG_STEP_US]  = step_code(16);
          vals[REG_STEP_DF]  = step_code(16);
          vals[REG_STEP_DS]  = step_code(16);
          vals[REG_MAX_VOL]  = CFG_W'(100);
        end
        default: begin
          trio = {$urandom_range(0, MAG_CAP), $urandom_range(0, MAG_CAP),
                  $urandom_range(0, MAG_CAP)};
          // ordered thresholds in some phases, any order in the rest
          if (p < 5) trio.sort();
          vals[REG_THR_MOD]  = CFG_W'(trio[0]);
          vals[REG_THR_LOW]  = CFG_W'(trio[1]);
          vals[REG_THR_HIGH] = (p == 2) ? CFG_W'(MAG_CAP - 1) : CFG_W'(trio[2]);
          vals[REG_STEP_UF]  = step_code($urandom_range(0, 32) - 16);
          vals[REG_STEP_US]  = step_code($urandom_range(0, 32) - 16);
          vals[REG_STEP_DF]  = step_code($urandom_range(0, 32) - 16);
          vals[REG_STEP_DS]  = step_code($urandom_range(0, 32) - 16);
          if (p == 5) vals[REG_MAX_VOL] = CFG_W'($urandom_range(0, MIN_VOLUME_DEF - 1));
          else if (p == 6) vals[REG_MAX_VOL] = CFG_W'(MIN_VOLUME_DEF);
          else vals[REG_MAX_VOL] = CFG_W'($urandom_range(0, 100));
        end
      endcase
      load_settings(vals);
      edges[0] = vals[REG_THR_HIGH];
      edges[1] = vals[REG_THR_LOW];
      edges[2] = vals[REG_THR_MOD];
      count = 0;
      while (count < PHASE_SAMPLES) begin
        len = $urandom_range(1, 7);
        case ($urandom_range(0, 3))
          0:       cap = edges[0];
          1:       cap = edges[1];
          2:       cap = edges[2];
          default: cap = MAG_CAP;
        endcase
        for (int k = 0; k < len; k++) add_sample(pick_sample(cap, edges), k == len - 1);
        count += len;
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bpa_pkg.sv
sv/bpa_cfg_regs.sv
sv/bpa_classify.sv
sv/bpa_gain.sv
sv/block_peak_agc_unit.sv
bench/tb.sv
